FILE: src/tgadec_pkg.sv
// Shared types and constants for the TGA RLE pixel decoder.
// No dependencies; tgadec_core and tga_rle_pixel_decoder import this package.
package tgadec_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] CFG_RLE_ENABLE   = 2'd1;
    localparam logic [1:0] CFG_PIXEL_TOTAL  = 2'd2;

    // Pixel format codes; the unused code decodes like BGRA.
    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_BGR  = 2'd1;
    localparam logic [1:0] FMT_BGRA = 2'd2;

    // Packet header fields.
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
    localparam logic [7:0] HDR_RUN_BIT    = 8'h80;

    // Register values after reset.
    localparam logic [1:0]  RST_PIXEL_FORMAT = FMT_BGR;
    localparam logic        RST_RLE_ENABLE   = 1'b1;
    localparam logic [31:0] RST_PIXEL_TOTAL  = 32'd1;

    // Current configuration, as seen by the decoder core.
    typedef struct packed {
        logic [1:0]  pixel_format;
        logic        rle_enable;
        logic [31:0] pixel_total;
    } t_cfg;

    // One decoded pixel request.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       image_done;
        logic       run_clipped;
    } t_pix;

endpackage

FILE: src/tgadec_byte_if.sv
// Input channel of the decoder: one image data byte per request.
// Uses no package.
interface tgadec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: src/tgadec_pix_if.sv
// Output channel of the decoder: one RGBA pixel with repeat count per request.
// Uses no package.
interface tgadec_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;
    logic       run_clipped;

    modport source (
        output valid, output red, output green, output blue, output alpha,
        output repeat_count, output image_done, output run_clipped,
        input ready
    );
    modport sink (
        input valid, input red, input green, input blue, input alpha,
        input repeat_count, input image_done, input run_clipped,
        output ready
    );
endinterface

FILE: src/tgadec_core.sv
// Decoder core: packet and pixel state, updated once per data byte.
// Depends on tgadec_pkg.
module tgadec_core
    import tgadec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_data_byte,
    input  t_cfg       i_cfg,
    output logic       o_emit,
    output t_pix       o_pix
);

    logic        r_expect_header, n_expect_header;
    logic        r_packet_is_run, n_packet_is_run;
    logic [7:0]  r_packet_left,   n_packet_left;
    logic [1:0]  r_byte_in_pixel, n_byte_in_pixel;
    logic [23:0] r_color_bytes,   n_color_bytes;
    logic [31:0] r_pixels_left,   n_pixels_left;

    logic [31:0] pl;
    logic        eh;
    logic [1:0]  bip;
    logic [2:0]  bytes_needed;
    logic [7:0]  run_count;
    logic [31:0] count_wide;
    logic [7:0]  left_dec;

    // Bytes per pixel for the current format.
    always_comb begin
        case (i_cfg.pixel_format)
            FMT_GRAY: bytes_needed = 3'd1;
            FMT_BGR:  bytes_needed = 3'd3;
            default:  bytes_needed = 3'd4;
        endcase
    end

    // Next state and pixel result for the byte at the input.
    always_comb begin
        pl  = r_pixels_left;
        eh  = r_expect_header;
        bip = r_byte_in_pixel;
        // A byte arriving with no image in progress starts a new one.
        if (r_pixels_left == 32'd0) begin
            pl  = (i_cfg.pixel_total == 32'd0) ? 32'd1 : i_cfg.pixel_total;
            eh  = 1'b1;
            bip = 2'd0;
        end

        n_pixels_left   = pl;
        n_expect_header = eh;
        n_byte_in_pixel = bip;
        n_packet_is_run = r_packet_is_run;
        n_packet_left   = r_packet_left;
        n_color_bytes   = r_color_bytes;
        run_count       = 8'd1;
        count_wide      = 32'd1;
        left_dec        = 8'd0;
        o_emit          = 1'b0;
        o_pix           = '0;

        if (i_cfg.rle_enable && eh) begin
            // Packet header byte.
            n_packet_is_run = (i_data_byte & HDR_RUN_BIT) != 8'd0;
            n_packet_left   = (i_data_byte & HDR_COUNT_MASK) + 8'd1;
            n_expect_header = 1'b0;
            n_byte_in_pixel = 2'd0;
        end else if (({1'b0, bip} + 3'd1) < bytes_needed) begin
            // Leading color byte of a pixel.
            case (bip)
                2'd0:    n_color_bytes[7:0]   = i_data_byte;
                2'd1:    n_color_bytes[15:8]  = i_data_byte;
                2'd2:    n_color_bytes[23:16] = i_data_byte;
                default: n_color_bytes        = r_color_bytes;
            endcase
            n_byte_in_pixel = bip + 2'd1;
        end else begin
            // Last byte of a pixel: swap to RGB(A) and emit.
            o_emit = 1'b1;
            case (bytes_needed)
                3'd1: begin
                    o_pix.red = i_data_byte;
                end
                3'd3: begin
                    o_pix.blue  = r_color_bytes[7:0];
                    o_pix.green = r_color_bytes[15:8];
                    o_pix.red   = i_data_byte;
                end
                default: begin
                    o_pix.blue  = r_color_bytes[7:0];
                    o_pix.green = r_color_bytes[15:8];
                    o_pix.red   = r_color_bytes[23:16];
                    o_pix.alpha = i_data_byte;
                end
            endcase
            n_byte_in_pixel = 2'd0;

            if (i_cfg.rle_enable && r_packet_is_run) begin
                // Run packet: one pixel covers the whole count, cut at the image end.
                run_count = (r_packet_left == 8'd0) ? 8'd1 : r_packet_left;
                if ({24'd0, run_count} > pl) begin
                    count_wide        = pl;
                    o_pix.run_clipped = 1'b1;
                end else begin
                    count_wide = {24'd0, run_count};
                end
                n_packet_left   = 8'd0;
                n_expect_header = 1'b1;
            end else begin
                count_wide = 32'd1;
                if (i_cfg.rle_enable) begin
                    // Raw packet: one pixel per request.
                    if (r_packet_left > 8'd1 && pl == 32'd1) begin
                        o_pix.run_clipped = 1'b1;
                    end
                    left_dec = (r_packet_left != 8'd0) ? r_packet_left - 8'd1 : 8'd0;
                    n_packet_left = left_dec;
                    if (left_dec == 8'd0) begin
                        n_expect_header = 1'b1;
                    end
                end
            end

            o_pix.repeat_count = count_wide[7:0];
            n_pixels_left      = pl - count_wide;
            o_pix.image_done   = (n_pixels_left == 32'd0);
            if (n_pixels_left == 32'd0) begin
                n_expect_header = 1'b1;
                n_packet_left   = 8'd0;
            end
        end
    end

    // State registers, advanced once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header <= 1'b1;
            r_packet_is_run <= 1'b0;
            r_packet_left   <= 8'd0;
            r_byte_in_pixel <= 2'd0;
            r_color_bytes   <= 24'd0;
            r_pixels_left   <= 32'd0;
        end else if (i_en) begin
            r_expect_header <= n_expect_header;
            r_packet_is_run <= n_packet_is_run;
            r_packet_left   <= n_packet_left;
            r_byte_in_pixel <= n_byte_in_pixel;
            r_color_bytes   <= n_color_bytes;
            r_pixels_left   <= n_pixels_left;
        end
    end

endmodule

FILE: src/tga_rle_pixel_decoder.sv
// TGA RLE pixel decoder, top level: input register, decoder core, output register.
// A pixel reaches the output through the input register and then the output register.
// One byte per cycle while the output register can take a result.
// Output backpressure stalls the input register, which then holds the byte.
// Synchronous active-low reset clears the pipeline and the packet state and
// restores format BGR, RLE on, and an image size of one pixel.
module tga_rle_pixel_decoder
    import tgadec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tgadec_byte_if.sink   i_byte,
    tgadec_pix_if.source  o_pix,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_pix       r_out;
    logic       out_free;
    logic       advance;
    logic       core_emit;
    t_pix       core_pix;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format <= RST_PIXEL_FORMAT;
            r_cfg.rle_enable   <= RST_RLE_ENABLE;
            r_cfg.pixel_total  <= RST_PIXEL_TOTAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PIXEL_FORMAT: r_cfg.pixel_format <= i_cfg_data[1:0];
                CFG_RLE_ENABLE:   r_cfg.rle_enable   <= i_cfg_data[0];
                CFG_PIXEL_TOTAL:  r_cfg.pixel_total  <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // Handshake: the held byte advances when the output register can take a result.
    assign out_free     = !r_out_valid || o_pix.ready;
    assign advance      = r_in_valid && out_free;
    assign i_byte.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
        end
    end

    tgadec_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_data_byte (r_in_byte),
        .i_cfg       (r_cfg),
        .o_emit      (core_emit),
        .o_pix       (core_pix)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && core_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_emit) begin
            r_out <= core_pix;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.red          = r_out.red;
    assign o_pix.green        = r_out.green;
    assign o_pix.blue         = r_out.blue;
    assign o_pix.alpha        = r_out.alpha;
    assign o_pix.repeat_count = r_out.repeat_count;
    assign o_pix.image_done   = r_out.image_done;
    assign o_pix.run_clipped  = r_out.run_clipped;

`ifndef SYNTH
    // A byte blocked by a full output register stays in the input register.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input byte lost while stalled");

    // Every pixel covers between one and one full packet of pixels.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (o_pix.repeat_count != 8'd0 && o_pix.repeat_count <= 8'd128))
        else $error("repeat count out of range");

    // A cut packet always ends the image.
    a_clip_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.run_clipped) |-> o_pix.image_done)
        else $error("clipped packet without image end");
`endif

endmodule
